FILE: sv/set_assoc_tag_store_lru_unit_macros.svh
`ifndef SET_ASSOC_TAG_STORE_LRU_UNIT_MACROS_SVH
`define SET_ASSOC_TAG_STORE_LRU_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SATS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SATS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// delayed implication
`define SATS_ASSERT_TWO(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

FILE: sv/sats_pkg.sv
`default_nettype none

package sats_pkg;

   // fixed field widths
   localparam int ADDR_W   = 32;
   localparam int TAG_W    = 32;
   localparam int SET_W    = 10;
   localparam int MAX_SETS = 1024;
   localparam int LRU_W    = 3;
   localparam int WAYO_W   = 3;
   localparam int CNT_W    = 5;
   localparam int SHIFT_W  = 6;

   // command codes
   localparam logic [2:0] CMD_LOOKUP = 3'd0;
   localparam logic [2:0] CMD_TOUCH  = 3'd1;
   localparam logic [2:0] CMD_VICTIM = 3'd2;
   localparam logic [2:0] CMD_FILL   = 3'd3;
   localparam logic [2:0] CMD_INVAL  = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_LOG_BLOCK = 2'd0;
   localparam logic [1:0] CSR_LOG_CACHE = 2'd1;
   localparam logic [1:0] CSR_LOG_WAYS  = 2'd2;

   // register reset values
   localparam logic [3:0] LOG_BLOCK_RST = 4'd4;
   localparam logic [4:0] LOG_CACHE_RST = 5'd12;
   localparam logic [1:0] LOG_WAYS_RST  = 2'd2;

   typedef struct packed {
      logic [3:0]         log_block;
      logic [CNT_W-1:0]   ways;
      logic [SHIFT_W-1:0] tag_shift;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [LRU_W-1:0] lru;
   } meta_type;

   typedef struct packed {
      logic              hit;
      logic [WAYO_W-1:0] way_out;
      logic [SET_W-1:0]  set_index;
      logic              line_dirty;
      logic              victim_valid;
      logic [ADDR_W-1:0] victim_address;
   } rsp_type;

   typedef struct packed {
      logic tag_we;
      logic meta_we;
   } wr_type;

endpackage

`default_nettype wire

FILE: sv/set_assoc_tag_store_lru_unit.sv
// flow: the request and its set rows are registered at the accepting edge, the
//   way logic works on them in the execute state and the result register drives
//   the strobe; no new request is taken until the set rows are written back in
//   the execute state, during which busy is high
// reset: configuration returns to its reset values and a sweep over all 1024
//   sets clears valid, dirty and lru state, one set a cycle, with busy high
// results are strobed for one cycle and cannot be stalled
`default_nettype none

module set_assoc_tag_store_lru_unit #(
   parameter int MAX_WAYS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_address,
   input  logic [2:0]  req_way,
   input  logic        req_dirty,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [2:0]  rsp_way_out,
   output logic [9:0]  rsp_set_index,
   output logic        rsp_line_dirty,
   output logic        rsp_victim_valid,
   output logic [31:0] rsp_victim_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import sats_pkg::*;

   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [SET_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             accept;

   cfg_type          cfg;
   logic [SET_W-1:0] dec_set;
   logic [TAG_W-1:0] dec_tag;

   logic [2:0]       cmd_ff;
   logic [2:0]       way_ff;
   logic             dirty_ff;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;

   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
   meta_type [MAX_WAYS-1:0]        meta_mem [MAX_SETS];
   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_rd_ff;
   meta_type [MAX_WAYS-1:0]        meta_rd_ff;
   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_new;
   meta_type [MAX_WAYS-1:0]        meta_row_new;
   meta_type [MAX_WAYS-1:0]        meta_wdata;
   logic [SET_W-1:0]               meta_waddr;
   logic                           meta_we;
   logic                           tag_we;
   wr_type                         wr;

   rsp_type rsp_comb;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // configuration and address split
   sats_cfg #(
      .MAX_WAYS(MAX_WAYS)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .address  (req_address),
      .cfg      (cfg),
      .set_index(dec_set),
      .tag      (dec_tag)
   );

   // set compare and update
   sats_way_logic #(
      .MAX_WAYS(MAX_WAYS),
      .WAY_W   (WAY_W)
   ) u_way_logic (
      .command     (cmd_ff),
      .way         (way_ff),
      .dirty       (dirty_ff),
      .tag         (tag_ff),
      .set_index   (set_ff),
      .cfg         (cfg),
      .tag_row     (tag_rd_ff),
      .meta_row    (meta_rd_ff),
      .tag_row_new (tag_row_new),
      .meta_row_new(meta_row_new),
      .wr          (wr),
      .rsp         (rsp_comb)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + SET_W'(1);
            if (clr_cnt_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         default: begin
            state_in   = ST_CLEAR;
            clr_cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         way_ff   <= req_way;
         dirty_ff <= req_dirty;
         set_ff   <= dec_set;
         tag_ff   <= dec_tag;
      end
   end

   // write-back control, clearing sweep takes the meta port
   always_comb begin
      tag_we     = (state_ff == ST_EXEC) && wr.tag_we;
      meta_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_EXEC) && wr.meta_we);
      meta_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : set_ff;
      meta_wdata = (state_ff == ST_CLEAR) ? '0 : meta_row_new;
   end

   // tag rows
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[set_ff] <= tag_row_new;
      end
      tag_rd_ff <= tag_mem[dec_set];
   end

   // valid, dirty and lru rows
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[dec_set];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_EXEC);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         rsp_ff <= rsp_comb;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_ff.hit;
   assign rsp_way_out        = rsp_ff.way_out;
   assign rsp_set_index      = rsp_ff.set_index;
   assign rsp_line_dirty     = rsp_ff.line_dirty;
   assign rsp_victim_valid   = rsp_ff.victim_valid;
   assign rsp_victim_address = rsp_ff.victim_address;

endmodule

`default_nettype wire

FILE: sv/sats_cfg.sv
`default_nettype none

module sats_cfg #(
   parameter int MAX_WAYS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [7:0]                  csr_wdata,
   input  logic [sats_pkg::ADDR_W-1:0] address,
   output sats_pkg::cfg_type           cfg,
   output logic [sats_pkg::SET_W-1:0]  set_index,
   output logic [sats_pkg::TAG_W-1:0]  tag
);
   import sats_pkg::*;

   logic [3:0]         log_block_ff;
   logic [4:0]         log_cache_ff;
   logic [1:0]         log_ways_ff;
   logic [CNT_W-1:0]   ways_pow;
   logic [6:0]         set_diff;
   logic [4:0]         set_bits;
   logic [ADDR_W-1:0]  addr_shifted;
   logic [SET_W-1:0]   set_mask;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         log_block_ff <= LOG_BLOCK_RST;
         log_cache_ff <= LOG_CACHE_RST;
         log_ways_ff  <= LOG_WAYS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOG_BLOCK: log_block_ff <= csr_wdata[3:0];
            CSR_LOG_CACHE: log_cache_ff <= csr_wdata[4:0];
            CSR_LOG_WAYS:  log_ways_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // derived geometry
   always_comb begin
      ways_pow = CNT_W'(1) << log_ways_ff;
      cfg.ways = (ways_pow > CNT_W'(MAX_WAYS)) ? CNT_W'(MAX_WAYS) : ways_pow;
      set_diff = {2'b00, log_cache_ff} - {3'b000, log_block_ff} - {5'b00000, log_ways_ff};
      set_bits = set_diff[6] ? 5'd0 : set_diff[4:0];
      cfg.log_block = log_block_ff;
      cfg.tag_shift = {2'b00, log_block_ff} + {1'b0, set_bits};
   end

   // set and tag split of the address
   always_comb begin
      addr_shifted = address >> log_block_ff;
      set_mask     = ~({SET_W{1'b1}} << set_bits);
      set_index    = addr_shifted[SET_W-1:0] & set_mask;
      tag          = address >> cfg.tag_shift;
   end

endmodule

`default_nettype wire

FILE: sv/sats_way_logic.sv
`default_nettype none

module sats_way_logic #(
   parameter int MAX_WAYS = 8,
   parameter int WAY_W    = 3
) (
   input  logic [2:0]                                 command,
   input  logic [2:0]                                 way,
   input  logic                                       dirty,
   input  logic [sats_pkg::TAG_W-1:0]                 tag,
   input  logic [sats_pkg::SET_W-1:0]                 set_index,
   input  sats_pkg::cfg_type                          cfg,
   input  logic [MAX_WAYS-1:0][sats_pkg::TAG_W-1:0]   tag_row,
   input  sats_pkg::meta_type [MAX_WAYS-1:0]          meta_row,
   output logic [MAX_WAYS-1:0][sats_pkg::TAG_W-1:0]   tag_row_new,
   output sats_pkg::meta_type [MAX_WAYS-1:0]          meta_row_new,
   output sats_pkg::wr_type                           wr,
   output sats_pkg::rsp_type                          rsp
);
   import sats_pkg::*;

   logic              way_ok;
   logic [WAY_W-1:0]  way_idx;
   logic              hit;
   logic [WAYO_W-1:0] hit_way;
   logic              hit_dirty;
   logic              inv_found;
   logic [WAYO_W-1:0] inv_way;
   logic              zero_found;
   logic [WAY_W-1:0]  zero_idx;
   logic [LRU_W-1:0]  old_lru;
   logic [CNT_W-1:0]  ways_m1;

   assign way_ok  = {{(CNT_W-3){1'b0}}, way} < cfg.ways;
   assign way_idx = WAY_W'(way);
   assign ways_m1 = cfg.ways - CNT_W'(1);
   assign old_lru = meta_row[way_idx].lru;

   // priority scans over the ways in use
   always_comb begin
      hit        = 1'b0;
      hit_way    = '0;
      hit_dirty  = 1'b0;
      inv_found  = 1'b0;
      inv_way    = '0;
      zero_found = 1'b0;
      zero_idx   = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (CNT_W'(i) < cfg.ways) begin
            if (!hit && meta_row[i].valid && tag_row[i] == tag) begin
               hit       = 1'b1;
               hit_way   = WAYO_W'(i);
               hit_dirty = meta_row[i].dirty;
            end
            if (!inv_found && !meta_row[i].valid) begin
               inv_found = 1'b1;
               inv_way   = WAYO_W'(i);
            end
            if (!zero_found && meta_row[i].lru == '0) begin
               zero_found = 1'b1;
               zero_idx   = WAY_W'(i);
            end
         end
      end
   end

   // result
   always_comb begin
      rsp                = '0;
      rsp.set_index      = set_index;
      case (command)
         CMD_LOOKUP: begin
            rsp.hit        = hit;
            rsp.way_out    = hit_way;
            rsp.line_dirty = hit_dirty;
         end
         CMD_VICTIM: begin
            if (inv_found) begin
               rsp.way_out        = inv_way;
               rsp.victim_address = '1;
            end else begin
               rsp.way_out        = WAYO_W'(zero_idx);
               rsp.victim_valid   = 1'b1;
               rsp.line_dirty     = meta_row[zero_idx].dirty;
               rsp.victim_address = (tag_row[zero_idx] << cfg.tag_shift) |
                                    (ADDR_W'(set_index) << cfg.log_block);
            end
         end
         default: ;
      endcase
   end

   // updated rows and write enables
   always_comb begin
      tag_row_new  = tag_row;
      meta_row_new = meta_row;
      wr           = '0;
      if (way_ok) begin
         case (command)
            CMD_TOUCH: begin
               wr.meta_we = 1'b1;
               for (int i = 0; i < MAX_WAYS; i++) begin
                  if (CNT_W'(i) < cfg.ways) begin
                     if (WAY_W'(i) == way_idx) begin
                        meta_row_new[i].lru = ways_m1[LRU_W-1:0];
                     end else if (meta_row[i].lru > old_lru) begin
                        meta_row_new[i].lru = meta_row[i].lru - LRU_W'(1);
                     end
                  end
               end
            end
            CMD_FILL: begin
               wr.tag_we                  = 1'b1;
               wr.meta_we                 = 1'b1;
               tag_row_new[way_idx]        = tag;
               meta_row_new[way_idx].dirty = dirty;
               meta_row_new[way_idx].valid = 1'b1;
            end
            CMD_INVAL: begin
               wr.meta_we                  = 1'b1;
               meta_row_new[way_idx].valid = 1'b0;
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: sv/sats_checker.sv
`default_nettype none
`include "set_assoc_tag_store_lru_unit_macros.svh"

module sats_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_hit,
   input logic rsp_line_dirty,
   input logic rsp_victim_valid
);

   // every accepted request yields its result through the execute state and the result register
   `SATS_ASSERT_TWO(a_rsp_follows, start && !busy, rsp_valid, "request without result")

   // the block is busy while a request is in flight
   `SATS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after accept")

   // results never come back to back
   `SATS_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe held")

   // a dirty report belongs to a hit or a valid victim
   `SATS_ASSERT_SAME(a_dirty_source, rsp_valid && rsp_line_dirty, rsp_hit || rsp_victim_valid, "stray dirty flag")

endmodule

bind set_assoc_tag_store_lru_unit sats_checker u_checker (.*);

`default_nettype wire
